// ===== hdl/lrsd_pkg.sv =====
// Shared types, codes and colour helpers for the LED ring status display.
// No dependencies; every design file except lrsd_ifs imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lrsd_pkg;

  // Ring geometry
  localparam int unsigned RING_SIZE = 12;
  localparam int unsigned LED_IDX_W = 4;
  typedef logic [LED_IDX_W-1:0] led_idx_t;
  localparam led_idx_t LED_LAST = LED_IDX_W'(RING_SIZE - 1);

  // Item and register fields
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [SCALE_W-1:0] PRESSURE_SCALE_RST = 16'd4096;
  localparam logic [SCALE_W-1:0] FLOW_SCALE_RST = 16'd8192;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_SCALE = 2'd1;

  // Operation codes
  localparam logic [1:0] OP_STATE = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // Machine states
  localparam logic [2:0] MS_IDLE = 3'd0;
  localparam logic [2:0] MS_ESPRESSO = 3'd1;
  localparam logic [2:0] MS_STEAM = 3'd2;
  localparam logic [2:0] MS_HOT_WATER = 3'd3;
  localparam logic [2:0] MS_FLUSH = 3'd4;

  // Function codes
  localparam logic [2:0] FN_NONE = 3'd0;
  localparam logic [2:0] FN_ESPRESSO = 3'd1;
  localparam logic [2:0] FN_STEAM = 3'd2;
  localparam logic [2:0] FN_HOT_WATER = 3'd3;
  localparam logic [2:0] FN_FLUSH = 3'd4;

  // Dot arithmetic: position is 12.20 fixed point
  localparam int unsigned POS_W = 32;
  localparam int unsigned FRAC_BITS = 20;
  localparam int unsigned PROD_W = 28;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(RING_SIZE - 1) << FRAC_BITS;
  localparam logic [7:0] DOT_PEAK = 8'd200;
  localparam logic [7:0] TAIL_MIN = 8'd10;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 16'd26;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } colour_t;

  localparam colour_t COL_GREY = '{r: 8'd30, g: 8'd30, b: 8'd30};
  localparam colour_t COL_RED = '{r: 8'd255, g: 8'd50, b: 8'd50};
  localparam colour_t COL_STEAM = '{r: 8'd100, g: 8'd150, b: 8'd255};
  localparam colour_t COL_HOT = '{r: 8'd255, g: 8'd200, b: 8'd100};
  localparam colour_t COL_FLUSH = '{r: 8'd100, g: 8'd200, b: 8'd255};

  typedef enum logic [2:0] {
    PAINT_GREY,
    PAINT_STEAM,
    PAINT_HOT,
    PAINT_FLUSH,
    PAINT_RED,
    PAINT_DOTS
  } paint_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DOT,
    ST_LOAD,
    ST_EMIT
  } ctrl_state_t;

  // One dot split over two neighbouring LEDs
  typedef struct packed {
    logic       en;
    led_idx_t   lo;
    logic [7:0] a1;
    led_idx_t   hi;
    logic       a2_en;
    logic [7:0] a2;
  } dot_t;

  // Control handed to every cell of the chain
  typedef struct packed {
    logic   load;
    logic   shift;
    paint_t kind;
    dot_t   gdot;
    dot_t   bdot;
  } cell_cmd_t;

  function automatic colour_t pattern_colour(paint_t kind, led_idx_t idx);
    colour_t c;
    c = COL_GREY;
    case (kind)
      PAINT_STEAM: if (idx >= 4'd2 && idx <= 4'd4) c = COL_STEAM;
      PAINT_HOT:   if (idx == LED_LAST || idx == 4'd0 || idx == 4'd1) c = COL_HOT;
      PAINT_FLUSH: if (idx >= 4'd8 && idx <= 4'd10) c = COL_FLUSH;
      PAINT_RED:   c = COL_RED;
      default:     c = COL_GREY;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] dot_amount(dot_t d, led_idx_t idx);
    logic [7:0] a;
    a = 8'd0;
    if (d.en && d.lo == idx) a = d.a1;
    else if (d.en && d.a2_en && d.hi == idx) a = d.a2;
    return a;
  endfunction

  function automatic logic [7:0] sat_add(logic [7:0] base, logic [7:0] add);
    logic [8:0] s;
    s = {1'b0, base} + {1'b0, add};
    return s[8] ? 8'd255 : s[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lrsd_ifs.sv =====
// Valid/ready channels for machine events in and LED results out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lrsd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  machine_state;
  logic [15:0] pressure;
  logic [15:0] flow;

  modport source (output valid, op, machine_state, pressure, flow, input ready);
  modport sink (input valid, op, machine_state, pressure, flow, output ready);
endinterface

interface lrsd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [2:0] active_function;
  logic       stop_active;
  logic       last;

  modport source (output valid, led_index, red, green, blue, active_function,
                  stop_active, last, input ready);
  modport sink (input valid, led_index, red, green, blue, active_function,
                stop_active, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/lrsd_dot_calc.sv =====
// Two-stage dot placement: position multiply, then clamp and split into two amounts.
// Depends on lrsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrsd_dot_calc (
  input  wire logic                         clk,
  input  wire logic                         cap,
  input  wire logic                         adv,
  input  wire logic [lrsd_pkg::VALUE_W-1:0] value,
  input  wire logic [lrsd_pkg::SCALE_W-1:0] scale,
  output lrsd_pkg::dot_t                    dot
);
  import lrsd_pkg::*;

  logic [POS_W-1:0]     pos;
  logic                 seen;
  logic [POS_W-1:0]     pos_c;
  logic [FRAC_BITS-1:0] frac;
  logic [PROD_W-1:0]    prod;
  led_idx_t             lo;
  logic [7:0]           a2;
  logic [7:0]           a1;

  // Capture position and threshold on the input transfer
  always_ff @(posedge clk) begin
    if (cap) begin
      pos  <= POS_W'(value) * POS_W'(scale);
      seen <= (value >= VALUE_MIN);
    end
  end

  // Clamp, split fraction; first amount is the peak less the rounded-up tail
  always_comb begin
    pos_c = (pos > POS_MAX) ? POS_MAX : pos;
    frac  = pos_c[FRAC_BITS-1:0];
    lo    = pos_c[FRAC_BITS +: LED_IDX_W];
    prod  = PROD_W'(frac) * PROD_W'(DOT_PEAK);
    a2    = prod[PROD_W-1:FRAC_BITS];
    a1    = DOT_PEAK - a2 - {7'd0, |prod[FRAC_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dot.en    <= seen;
      dot.lo    <= lo;
      dot.hi    <= (lo == LED_LAST) ? '0 : lo + 1'b1;
      dot.a1    <= a1;
      dot.a2    <= a2;
      dot.a2_en <= (a2 > TAIL_MIN);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lrsd_cell.sv =====
// One LED cell of the ring chain: holds a colour, loads its pattern, hands it on.
// Depends on lrsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrsd_cell #(
  parameter lrsd_pkg::led_idx_t IDX = '0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lrsd_pkg::cell_cmd_t cmd,
  input  wire lrsd_pkg::colour_t   nbr,
  output lrsd_pkg::colour_t        colour
);
  import lrsd_pkg::*;

  colour_t base;
  colour_t load_val;

  // Pattern colour for this position, with dots added during espresso
  always_comb begin
    base     = pattern_colour(cmd.kind, IDX);
    load_val = base;
    if (cmd.kind == PAINT_DOTS) begin
      load_val.g = sat_add(base.g, dot_amount(cmd.gdot, IDX));
      load_val.b = sat_add(base.b, dot_amount(cmd.bdot, IDX));
    end
  end

  // Load a fresh ring or advance one place towards the output end
  always_ff @(posedge clk) begin
    if (rst) begin
      colour <= COL_GREY;
    end else if (cmd.load) begin
      colour <= load_val;
    end else if (cmd.shift) begin
      colour <= nbr;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/led_ring_status_display_core.sv =====
// LED ring status display: one machine event in, the whole 12-LED ring out, LED 0 first.
// Depends on lrsd_pkg, lrsd_ifs, lrsd_dot_calc and lrsd_cell.
//
// Each event that changes the display is taken in one transfer, then the pressure and
// flow dots are placed (ST_DOT) and the ring of cells is loaded (ST_LOAD); the twelve
// LED results then leave one per cycle while the sink is ready, from the end of the cell
// chain, which rotates so that the ring is back in place after the last one. No new event
// is taken until the last LED result has left; an event that changes nothing (sample
// outside espresso or while stopped, state change while stopped) gives no results. The
// serial readout through the single output end of the chain keeps the next event waiting.
// Reset leaves the ring grey, no function and no stop; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module led_ring_status_display_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  lrsd_in_if.sink                             events,
  lrsd_out_if.source                          leds,
  input  wire logic                           cfg_we,
  input  wire logic [lrsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lrsd_pkg::SCALE_W-1:0]   cfg_wdata
);
  import lrsd_pkg::*;

  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [SCALE_W-1:0]   pressure_scale;
  logic [SCALE_W-1:0]   flow_scale;
  logic [2:0]           func;
  logic                 stop_held;
  paint_t               kind;
  paint_t               kind_sel;
  logic [2:0]           fn_sel;
  logic                 emits;
  logic                 accept;
  logic                 out_xfer;
  led_idx_t             emit_idx;
  cell_cmd_t            cmd;
  colour_t              ring [RING_SIZE];

  assign events.ready = (state == ST_IDLE);
  assign accept       = events.valid && events.ready;
  assign out_xfer     = leds.valid && leds.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_scale <= PRESSURE_SCALE_RST;
      flow_scale     <= FLOW_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESSURE_SCALE: pressure_scale <= cfg_wdata;
        REG_FLOW_SCALE:     flow_scale <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // Decode the event: pattern and function for the machine state, and whether it shows
  always_comb begin
    case (events.machine_state)
      MS_ESPRESSO:  begin kind_sel = PAINT_GREY;  fn_sel = FN_ESPRESSO;  end
      MS_STEAM:     begin kind_sel = PAINT_STEAM; fn_sel = FN_STEAM;     end
      MS_HOT_WATER: begin kind_sel = PAINT_HOT;   fn_sel = FN_HOT_WATER; end
      MS_FLUSH:     begin kind_sel = PAINT_FLUSH; fn_sel = FN_FLUSH;     end
      default:      begin kind_sel = PAINT_GREY;  fn_sel = FN_NONE;      end
    endcase
    case (events.op)
      OP_STATE:  emits = !stop_held;
      OP_SAMPLE: emits = !stop_held && (func == FN_ESPRESSO);
      default:   emits = 1'b1;
    endcase
  end

  // Update function, stop flag and paint kind on the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      func      <= FN_NONE;
      stop_held <= 1'b0;
    end else if (accept) begin
      case (events.op)
        OP_STATE: if (!stop_held) func <= fn_sel;
        OP_STOP:  stop_held <= 1'b1;
        OP_RELEASE: begin
          stop_held <= 1'b0;
          func      <= fn_sel;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (events.op)
        OP_SAMPLE: kind <= PAINT_DOTS;
        OP_STOP:   kind <= PAINT_RED;
        default:   kind <= kind_sel;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && emits) state_next = ST_DOT;
      ST_DOT:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_EMIT;
      ST_EMIT: if (out_xfer && emit_idx == LED_LAST) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Count LEDs out
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (out_xfer) begin
      emit_idx <= (emit_idx == LED_LAST) ? '0 : emit_idx + 1'b1;
    end
  end

  // Dot placement for pressure and flow
  lrsd_dot_calc u_gdot (
    .clk   (clk),
    .cap   (accept),
    .adv   (state == ST_DOT),
    .value (events.pressure),
    .scale (pressure_scale),
    .dot   (cmd.gdot)
  );

  lrsd_dot_calc u_bdot (
    .clk   (clk),
    .cap   (accept),
    .adv   (state == ST_DOT),
    .value (events.flow),
    .scale (flow_scale),
    .dot   (cmd.bdot)
  );

  assign cmd.load  = (state == ST_LOAD);
  assign cmd.shift = out_xfer;
  assign cmd.kind  = kind;

  // Ring of cells, each handing its colour to the one below; cell 0 drives the output
  for (genvar i = 0; i < RING_SIZE; i++) begin : g_cell
    lrsd_cell #(
      .IDX (LED_IDX_W'(i))
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .nbr    (ring[(i + 1) % RING_SIZE]),
      .colour (ring[i])
    );
  end

  assign leds.valid           = (state == ST_EMIT);
  assign leds.led_index       = emit_idx;
  assign leds.red             = ring[0].r;
  assign leds.green           = ring[0].g;
  assign leds.blue            = ring[0].b;
  assign leds.active_function = func;
  assign leds.stop_active     = stop_held;
  assign leds.last            = (emit_idx == LED_LAST);

  // One item at a time: no new event while the ring is being read out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    leds.valid |-> !events.ready)
    else $error("event accepted during ring readout");

  // An accepted stop press always sets the stop flag
  a_stop_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && events.op == OP_STOP) |=> stop_held)
    else $error("stop flag not set after stop press");

  // The ring ends after its final LED
  a_ring_ends: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && leds.last) |=> !leds.valid)
    else $error("results continue past final LED");

  // Index wraps to the first LED once a ring is done
  a_idx_wrap: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && leds.last) |=> (emit_idx == '0))
    else $error("LED index did not wrap");

endmodule

`default_nettype wire
